// ===== design/i2c_fram_random_access_master_defines.svh =====
// ----------------------------------------------------------------------------
// I2C FRAM master - assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef I2C_FRAM_RANDOM_ACCESS_MASTER_DEFINES_SVH
`define I2C_FRAM_RANDOM_ACCESS_MASTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CFRAM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CFRAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CFRAM_ASSERT(lbl, ante, cons, msg)
`define I2CFRAM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/i2cfram_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C FRAM master - package
// Widths, phase and byte-role codes, register indexes and result type.
// ----------------------------------------------------------------------------
package i2cfram_pkg;

  localparam int DEV_W     = 7;
  localparam int TICK_W    = 10;
  localparam int ADDR_W    = 16;
  localparam int CNT_W     = 14;
  localparam int BYTE_W    = 8;
  localparam int BIT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam logic [CNT_W-1:0] MAX_BYTES = 14'd8192;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_TX_LOW   = 4'd3,
    PH_TX_SETUP = 4'd4,
    PH_TX_HIGH  = 4'd5,
    PH_ACK_LOW  = 4'd6,
    PH_ACK_HIGH = 4'd7,
    PH_RX_LOW   = 4'd8,
    PH_RX_HIGH  = 4'd9,
    PH_RA_LOW   = 4'd10,
    PH_RA_SETUP = 4'd11,
    PH_RA_HIGH  = 4'd12,
    PH_RS_LOW   = 4'd13,
    PH_STOP_LOW = 4'd14,
    PH_STOP_HIGH = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_DEVW = 3'd0,
    ROLE_AHI  = 3'd1,
    ROLE_ALO  = 3'd2,
    ROLE_DEVR = 3'd3,
    ROLE_DATA = 3'd4
  } role_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEV_ADDR = 2'd0,
    REG_HOLD     = 2'd1,
    REG_SETUP    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_drive_low;
    logic              wr_byte_taken;
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_valid;
    logic              busy_res;
    logic              done_res;
    logic              status;
  } out_item_t;

endpackage

// ===== design/i2cfram_if.sv =====
// ----------------------------------------------------------------------------
// I2C FRAM master - channel interfaces
// Tick request, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cfram_in_if;
  import i2cfram_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_cmd;
  logic              req_type;
  logic [ADDR_W-1:0] mem_addr;
  logic [CNT_W-1:0]  byte_count;
  logic [BYTE_W-1:0] wr_byte;
  logic              sda_in;

  modport source (output valid, start_cmd, req_type, mem_addr, byte_count, wr_byte,
                  sda_in, input ready);
  modport sink   (input valid, start_cmd, req_type, mem_addr, byte_count, wr_byte,
                  sda_in, output ready);
endinterface

interface i2cfram_out_if;
  import i2cfram_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_drive_low;
  logic              wr_byte_taken;
  logic [BYTE_W-1:0] rd_byte;
  logic              rd_valid;
  logic              busy_res;
  logic              done_res;
  logic              status;

  modport source (output valid, scl_level, sda_drive_low, wr_byte_taken, rd_byte,
                  rd_valid, busy_res, done_res, status, input ready);
  modport sink   (input valid, scl_level, sda_drive_low, wr_byte_taken, rd_byte,
                  rd_valid, busy_res, done_res, status, output ready);
endinterface

interface i2cfram_cfg_if;
  import i2cfram_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/i2c_fram_random_access_master.sv =====
// ----------------------------------------------------------------------------
// I2C FRAM random access master
// Tick-stepped I2C bit sequencer for 16-bit-addressed FRAM reads and writes.
// ----------------------------------------------------------------------------
// Each request on in_if is one timing tick of the I2C sequencer and yields
// exactly one result on out_if: the SCL level and SDA pull-down for that
// tick, write-byte handshake, received byte, busy/done and status. The block
// takes one request per clock: the phase logic is a single
// registered step from the state registers to a result register, and
// in_if.ready only drops while a finished result is stalled on out_if. A
// transfer starts on a tick with start_cmd while idle (that tick still shows
// idle). Writes: START, device byte (R/W=0), address high/low, data bytes,
// STOP. Reads: same header, repeated START, device byte (R/W=1), then bytes
// ACKed and the last one NACKed, STOP. A NACK on any sent byte ends with STOP
// and status=1. Phase lengths come from hold_ticks / setup_ticks (0 means 1
// tick); register writes on cfg_if take effect on the next tick.
`include "i2c_fram_random_access_master_defines.svh"

module i2c_fram_random_access_master (
  input  logic             clk,
  input  logic             rst_n,
  i2cfram_in_if.sink       in_if,
  i2cfram_out_if.source    out_if,
  i2cfram_cfg_if.sink      cfg_if
);
  import i2cfram_pkg::*;

  // configuration registers
  logic [DEV_W-1:0]  dev_addr_r;
  logic [TICK_W-1:0] hold_r;
  logic [TICK_W-1:0] setup_r;

  // sequencer state
  phase_t            phase_r, phase_nxt;
  role_t             role_r, role_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              is_read_r, is_read_nxt;
  logic              fail_r, fail_nxt;
  logic              sda_low_r, sda_low_nxt;

  // per-tick events
  logic              taken_c;
  logic              rdv_c;
  logic              done_c;
  logic              enter_c;

  // result register
  logic              out_valid_r;
  out_item_t         out_r;
  out_item_t         item_c;

  logic              in_acc;
  logic [TICK_W-1:0] dur_raw;
  logic [TICK_W-1:0] dur_eff;
  logic              phase_end;
  logic [CNT_W-1:0]  cnt_c;
  logic [CNT_W-1:0]  left_dec;

  // accept a new tick whenever the result slot is free or being drained
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // phase length: setup phases use setup_ticks, all others hold_ticks
  assign dur_raw   = (phase_r == PH_TX_SETUP || phase_r == PH_RA_SETUP) ? setup_r : hold_r;
  assign dur_eff   = (dur_raw == '0) ? TICK_W'(1) : dur_raw;
  assign phase_end = (phase_r != PH_IDLE) &&
                     (({1'b0, tick_r} + 11'd1) >= {1'b0, dur_eff});

  // command byte count: zero becomes one, clamp to MAX_BYTES
  always_comb begin
    cnt_c = in_if.byte_count;
    if (cnt_c == '0) begin
      cnt_c = CNT_W'(1);
    end else if (cnt_c > MAX_BYTES) begin
      cnt_c = MAX_BYTES;
    end
  end

  // data byte ACKed: one fewer byte to go
  assign left_dec = (role_r == ROLE_DATA && left_r != '0) ? (left_r - CNT_W'(1)) : left_r;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    role_nxt    = role_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    addr_nxt    = addr_r;
    is_read_nxt = is_read_r;
    fail_nxt    = fail_r;
    sda_low_nxt = sda_low_r;
    taken_c     = 1'b0;
    rdv_c       = 1'b0;
    done_c      = 1'b0;
    enter_c     = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (in_if.start_cmd) begin
        is_read_nxt = in_if.req_type;
        addr_nxt    = in_if.mem_addr;
        left_nxt    = cnt_c;
        fail_nxt    = 1'b0;
        role_nxt    = ROLE_DEVW;
        phase_nxt   = PH_START_A;
        enter_c     = 1'b1;
      end
    end else if (!phase_end) begin
      tick_nxt = tick_r + TICK_W'(1);
    end else begin
      enter_c = 1'b1;
      case (phase_r)
        PH_START_A:  phase_nxt = PH_START_B;
        PH_START_B: begin
          shift_nxt = {dev_addr_r, (role_r == ROLE_DEVR)};
          bit_nxt   = '0;
          phase_nxt = PH_TX_LOW;
        end
        PH_TX_LOW:   phase_nxt = PH_TX_SETUP;
        PH_TX_SETUP: phase_nxt = PH_TX_HIGH;
        PH_TX_HIGH: begin
          bit_nxt   = bit_r + BIT_W'(1);
          shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
          phase_nxt = (bit_r >= BIT_W'(BYTE_W - 1)) ? PH_ACK_LOW : PH_TX_LOW;
        end
        PH_ACK_LOW:  phase_nxt = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          if (in_if.sda_in) begin
            fail_nxt  = 1'b1;
            phase_nxt = PH_STOP_LOW;
          end else if (role_r == ROLE_DEVW) begin
            role_nxt  = ROLE_AHI;
            shift_nxt = addr_r[ADDR_W-1:BYTE_W];
            bit_nxt   = '0;
            phase_nxt = PH_TX_LOW;
          end else if (role_r == ROLE_AHI) begin
            role_nxt  = ROLE_ALO;
            shift_nxt = addr_r[BYTE_W-1:0];
            bit_nxt   = '0;
            phase_nxt = PH_TX_LOW;
          end else if (role_r == ROLE_ALO && is_read_r) begin
            role_nxt  = ROLE_DEVR;
            phase_nxt = PH_RS_LOW;
          end else if (role_r == ROLE_DEVR) begin
            role_nxt  = ROLE_DATA;
            shift_nxt = '0;
            bit_nxt   = '0;
            phase_nxt = PH_RX_LOW;
          end else begin
            left_nxt = left_dec;
            if (role_r == ROLE_DATA && left_dec == '0) begin
              phase_nxt = PH_STOP_LOW;
            end else begin
              role_nxt  = ROLE_DATA;
              taken_c   = 1'b1;
              shift_nxt = in_if.wr_byte;
              bit_nxt   = '0;
              phase_nxt = PH_TX_LOW;
            end
          end
        end
        PH_RS_LOW:   phase_nxt = PH_START_A;
        PH_RX_LOW:   phase_nxt = PH_RX_HIGH;
        PH_RX_HIGH: begin
          shift_nxt = {shift_r[BYTE_W-2:0], in_if.sda_in};
          bit_nxt   = bit_r + BIT_W'(1);
          if (bit_r >= BIT_W'(BYTE_W - 1)) begin
            rdv_c     = 1'b1;
            phase_nxt = PH_RA_LOW;
          end else begin
            phase_nxt = PH_RX_LOW;
          end
        end
        PH_RA_LOW:   phase_nxt = PH_RA_SETUP;
        PH_RA_SETUP: phase_nxt = PH_RA_HIGH;
        PH_RA_HIGH: begin
          left_nxt = (left_r != '0) ? (left_r - CNT_W'(1)) : left_r;
          if (left_nxt == '0) begin
            phase_nxt = PH_STOP_LOW;
          end else begin
            shift_nxt = '0;
            bit_nxt   = '0;
            phase_nxt = PH_RX_LOW;
          end
        end
        PH_STOP_LOW: phase_nxt = PH_STOP_HIGH;
        default: begin
          done_c    = 1'b1;
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // entering a phase restarts its timer and sets the SDA drive level
    if (enter_c) begin
      tick_nxt = '0;
      case (phase_nxt)
        PH_START_A, PH_ACK_HIGH, PH_RX_LOW, PH_RX_HIGH,
        PH_RA_LOW, PH_RS_LOW, PH_IDLE:          sda_low_nxt = 1'b0;
        PH_START_B, PH_STOP_LOW, PH_STOP_HIGH:  sda_low_nxt = 1'b1;
        PH_TX_SETUP: sda_low_nxt = !shift_nxt[BYTE_W-1];
        PH_RA_SETUP: sda_low_nxt = (left_nxt > CNT_W'(1));  // ACK unless last byte
        default:     sda_low_nxt = sda_low_r;
      endcase
    end
  end

  // result of this tick; line levels follow the phase the tick belongs to
  always_comb begin
    item_c = '0;
    case (phase_r)
      PH_IDLE, PH_START_A, PH_START_B, PH_TX_HIGH,
      PH_ACK_HIGH, PH_RX_HIGH, PH_RA_HIGH, PH_STOP_HIGH: item_c.scl_level = 1'b1;
      default: item_c.scl_level = 1'b0;
    endcase
    item_c.sda_drive_low = sda_low_r;
    item_c.wr_byte_taken = taken_c;
    item_c.rd_byte       = rdv_c ? shift_nxt : '0;
    item_c.rd_valid      = rdv_c;
    item_c.busy_res      = (phase_r != PH_IDLE);
    item_c.done_res      = done_c;
    item_c.status        = fail_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_W'(80);
      hold_r     <= TICK_W'(50);
      setup_r    <= TICK_W'(30);
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_DEV_ADDR: dev_addr_r <= cfg_if.data[DEV_W-1:0];
        REG_HOLD:     hold_r     <= cfg_if.data[TICK_W-1:0];
        REG_SETUP:    setup_r    <= cfg_if.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      role_r    <= ROLE_DEVW;
      tick_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      left_r    <= '0;
      addr_r    <= '0;
      is_read_r <= 1'b0;
      fail_r    <= 1'b0;
      sda_low_r <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      role_r    <= role_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      addr_r    <= addr_nxt;
      is_read_r <= is_read_nxt;
      fail_r    <= fail_nxt;
      sda_low_r <= sda_low_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= item_c;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.scl_level     = out_r.scl_level;
  assign out_if.sda_drive_low = out_r.sda_drive_low;
  assign out_if.wr_byte_taken = out_r.wr_byte_taken;
  assign out_if.rd_byte       = out_r.rd_byte;
  assign out_if.rd_valid      = out_r.rd_valid;
  assign out_if.busy_res      = out_r.busy_res;
  assign out_if.done_res      = out_r.done_res;
  assign out_if.status        = out_r.status;

  `I2CFRAM_ASSERT(a_bit_range, 1'b1, bit_r <= BIT_W'(BYTE_W), "bit index past a byte")
  `I2CFRAM_ASSERT(a_left_range, 1'b1, left_r <= MAX_BYTES, "byte count above limit")
  `I2CFRAM_ASSERT(a_idle_release, phase_r == PH_IDLE, !sda_low_r, "SDA held low while idle")
  `I2CFRAM_ASSERT_NEXT(a_done_idle, in_acc && done_c, phase_r == PH_IDLE,
    "transfer done but sequencer not idle")

endmodule
